// ===== rtl/length_prefixed_message_ring_core_macros.svh =====
// ----------------------------------------------------------------------------
// length prefixed message ring - assertion macros
// shared concurrent assertion forms, clocked on clk_i, off during reset
// ----------------------------------------------------------------------------
`ifndef LENGTH_PREFIXED_MESSAGE_RING_CORE_MACROS_SVH
`define LENGTH_PREFIXED_MESSAGE_RING_CORE_MACROS_SVH

// property must hold on every clock edge
`define LPMR_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// consequent must hold in the same cycle as the antecedent
`define LPMR_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) else $error(msg);

// consequent must hold in the cycle after the antecedent
`define LPMR_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) else $error(msg);

`endif

// ===== rtl/lpmr_pkg.sv =====
// ----------------------------------------------------------------------------
// lpmr_pkg
// types, codes and widths shared by the message ring modules
// ----------------------------------------------------------------------------
package lpmr_pkg;

  localparam int unsigned KIND_W   = 2;
  localparam int unsigned LEN_W    = 16;
  localparam int unsigned BYTE_W   = 8;
  localparam int unsigned POS_W    = 10;
  localparam int unsigned STATUS_W = 3;
  localparam int unsigned CFG_W    = 11;

  // wide enough for length + header and pointer sums
  localparam int unsigned ARITH_W  = 18;

  localparam int unsigned RING_DEPTH_DEFAULT = 1024;
  localparam int unsigned RING_SIZE_RESET    = 1024;
  localparam int unsigned MIN_SIZE           = 8;
  // two header bytes plus two bytes of slack
  localparam int unsigned HDR_BYTES          = 2 + 2;

  localparam int unsigned TDATA_IN_W   = 40;
  localparam int unsigned TUSER_IN_W   = 3;
  localparam int unsigned TDATA_OUT_W  = 40;
  localparam int unsigned TUSER_OUT_W  = 3;
  localparam int unsigned TDATA_OUT_PAD = TDATA_OUT_W - BYTE_W - LEN_W - POS_W;

  typedef enum logic [KIND_W-1:0] {
    KIND_WR_OPEN = 2'd0,
    KIND_WR_BYTE = 2'd1,
    KIND_RD_OPEN = 2'd2,
    KIND_RD_BYTE = 2'd3
  } kind_e;

  typedef enum logic [STATUS_W-1:0] {
    STATUS_OK        = 3'd0,
    STATUS_NO_SPACE  = 3'd1,
    STATUS_EMPTY     = 3'd2,
    STATUS_OVER_CAP  = 3'd3,
    STATUS_BAD_LEN   = 3'd4,
    STATUS_NONE_OPEN = 3'd5,
    STATUS_BAD_START = 3'd6
  } status_e;

  typedef struct packed {
    kind_e              kind;
    logic [LEN_W-1:0]   msg_length;
    logic [BYTE_W-1:0]  data_byte;
    logic               peek;
    logic [POS_W-1:0]   start_position;
  } item_t;

  typedef struct packed {
    status_e            status;
    logic [BYTE_W-1:0]  read_data;
    logic [LEN_W-1:0]   length;
    logic               last;
    logic [POS_W-1:0]   next_position;
  } res_t;

endpackage

// ===== rtl/lpmr_ram.sv =====
// ----------------------------------------------------------------------------
// lpmr_ram
// generic simple dual port ram, one write and one registered read port
// ----------------------------------------------------------------------------
module lpmr_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 1024,
  localparam int unsigned AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/lpmr_engine.sv =====
// ----------------------------------------------------------------------------
// lpmr_engine
// sequencer, pointer state and ring memory of the message ring
// ----------------------------------------------------------------------------
`include "length_prefixed_message_ring_core_macros.svh"

module lpmr_engine #(
  parameter int unsigned RING_DEPTH = lpmr_pkg::RING_DEPTH_DEFAULT
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_valid_i,
  output logic                       cfg_ready_o,
  input  logic [lpmr_pkg::CFG_W-1:0] cfg_data_i,
  input  logic                       item_valid_i,
  output logic                       item_ready_o,
  input  lpmr_pkg::item_t            item_i,
  output logic                       res_valid_o,
  input  logic                       res_ready_i,
  output lpmr_pkg::res_t             res_o
);

  localparam int unsigned PW = $clog2(RING_DEPTH);
  localparam int unsigned SW = PW + 1;
  localparam int unsigned AW = lpmr_pkg::ARITH_W;
  localparam logic [SW-1:0] SIZE_RST =
    SW'((lpmr_pkg::RING_SIZE_RESET > RING_DEPTH) ? RING_DEPTH : lpmr_pkg::RING_SIZE_RESET);

  typedef enum logic [5:0] {
    ST_IDLE    = 6'b000001,
    ST_WR_HDR  = 6'b000010,
    ST_RD_HI   = 6'b000100,
    ST_RD_LO   = 6'b001000,
    ST_RD_BYTE = 6'b010000,
    ST_EMIT    = 6'b100000
  } state_e;

  function automatic logic [PW-1:0] bump(input logic [PW-1:0] p, input logic [SW-1:0] s);
    logic [AW-1:0] n;
    n = AW'(p) + AW'(1);
    return (n >= AW'(s)) ? '0 : PW'(n);
  endfunction

  function automatic logic [SW-1:0] clamp_size(input logic [lpmr_pkg::CFG_W-1:0] v);
    logic [AW-1:0] e;
    e = AW'(v);
    if (e < AW'(lpmr_pkg::MIN_SIZE)) begin
      e = AW'(lpmr_pkg::MIN_SIZE);
    end else if (e > AW'(RING_DEPTH)) begin
      e = AW'(RING_DEPTH);
    end
    return SW'(e);
  endfunction

  state_e                         state_q, state_d;
  logic [SW-1:0]                  size_q, size_d;
  logic [PW-1:0]                  wp_q, wp_d, rp_q, rp_d;
  logic [PW-1:0]                  wcur_q, wcur_d, rcur_q, rcur_d;
  logic [lpmr_pkg::LEN_W-1:0]     wrem_q, wrem_d, rrem_q, rrem_d;
  logic                           wact_q, wact_d, ract_q, ract_d, rpeek_q, rpeek_d;
  logic [PW-1:0]                  pos_q, pos_d;
  logic [lpmr_pkg::BYTE_W-1:0]    hi_q, hi_d;
  lpmr_pkg::item_t                item_q, item_d;
  lpmr_pkg::res_t                 res_q, res_d;

  logic                           mem_we, mem_re;
  logic [PW-1:0]                  mem_waddr, mem_raddr;
  logic [lpmr_pkg::BYTE_W-1:0]    mem_wdata, mem_rdata;

  logic                           cfg_fire, item_fire, nospace;
  logic [PW-1:0]                  r_sel, r_nxt;
  logic [AW-1:0]                  need, hdr, nx;

  lpmr_ram #(
    .WIDTH (lpmr_pkg::BYTE_W),
    .DEPTH (RING_DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .re_i    (mem_re),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  assign cfg_ready_o  = (state_q == ST_IDLE);
  assign item_ready_o = (state_q == ST_IDLE) && !cfg_valid_i;
  assign cfg_fire     = cfg_valid_i && cfg_ready_o;
  assign item_fire    = item_valid_i && item_ready_o;
  assign res_valid_o  = (state_q == ST_EMIT);
  assign res_o        = res_q;

  // space check for a new message against the committed pointers
  always_comb begin
    need = AW'(item_i.msg_length) + AW'(lpmr_pkg::HDR_BYTES);
    if (wp_q < rp_q) begin
      nospace = (AW'(wp_q) + need) >= AW'(rp_q);
    end else begin
      nospace = ((AW'(size_q) - AW'(wp_q)) + AW'(rp_q)) < need;
    end
  end

  assign r_sel = item_i.peek ? PW'(AW'(item_i.start_position)) : rp_q;
  assign r_nxt = bump(r_sel, size_q);
  assign hdr   = AW'({hi_q, mem_rdata});

  always_comb begin
    state_d   = state_q;
    size_d    = size_q;
    wp_d      = wp_q;
    rp_d      = rp_q;
    wcur_d    = wcur_q;
    rcur_d    = rcur_q;
    wrem_d    = wrem_q;
    rrem_d    = rrem_q;
    wact_d    = wact_q;
    ract_d    = ract_q;
    rpeek_d   = rpeek_q;
    pos_d     = pos_q;
    hi_d      = hi_q;
    item_d    = item_q;
    res_d     = res_q;
    mem_we    = 1'b0;
    mem_waddr = wp_q;
    mem_wdata = item_i.msg_length[lpmr_pkg::LEN_W-1:lpmr_pkg::BYTE_W];
    mem_re    = 1'b0;
    mem_raddr = r_sel;
    nx        = AW'(pos_q) + hdr;
    if (nx >= AW'(size_q)) begin
      nx = nx - AW'(size_q);
    end

    case (state_q)
      ST_IDLE: begin
        if (cfg_fire) begin
          size_d = clamp_size(cfg_data_i);
          wp_d   = '0;
          rp_d   = '0;
          wact_d = 1'b0;
          ract_d = 1'b0;
          wrem_d = '0;
          rrem_d = '0;
        end else if (item_fire) begin
          item_d  = item_i;
          res_d   = '0;
          state_d = ST_EMIT;
          case (item_i.kind)
            lpmr_pkg::KIND_WR_OPEN: begin
              wact_d = 1'b0;
              if (nospace) begin
                res_d.status = lpmr_pkg::STATUS_NO_SPACE;
              end else begin
                mem_we  = 1'b1;
                pos_d   = bump(wp_q, size_q);
                state_d = ST_WR_HDR;
              end
            end
            lpmr_pkg::KIND_WR_BYTE: begin
              if (!wact_q) begin
                res_d.status = lpmr_pkg::STATUS_NONE_OPEN;
              end else begin
                mem_we    = 1'b1;
                mem_waddr = wcur_q;
                mem_wdata = item_i.data_byte;
                wcur_d    = bump(wcur_q, size_q);
                wrem_d    = wrem_q - lpmr_pkg::LEN_W'(1);
                if (wrem_q == lpmr_pkg::LEN_W'(1)) begin
                  wp_d       = bump(wcur_q, size_q);
                  wact_d     = 1'b0;
                  res_d.last = 1'b1;
                end
              end
            end
            lpmr_pkg::KIND_RD_OPEN: begin
              ract_d = 1'b0;
              mem_re = 1'b1;
              if (item_i.peek && (AW'(item_i.start_position) >= AW'(size_q))) begin
                res_d.status = lpmr_pkg::STATUS_BAD_START;
              end else if ((r_sel == wp_q) || (r_nxt == wp_q)) begin
                res_d.status = lpmr_pkg::STATUS_EMPTY;
              end else begin
                pos_d   = r_nxt;
                state_d = ST_RD_HI;
              end
            end
            lpmr_pkg::KIND_RD_BYTE: begin
              if (!ract_q) begin
                res_d.status = lpmr_pkg::STATUS_NONE_OPEN;
              end else begin
                mem_re    = 1'b1;
                mem_raddr = rcur_q;
                state_d   = ST_RD_BYTE;
              end
            end
            default: begin
              res_d.status = lpmr_pkg::STATUS_NONE_OPEN;
            end
          endcase
        end
      end
      ST_WR_HDR: begin
        mem_we    = 1'b1;
        mem_waddr = pos_q;
        mem_wdata = item_q.msg_length[lpmr_pkg::BYTE_W-1:0];
        if (item_q.msg_length == '0) begin
          wp_d       = bump(pos_q, size_q);
          res_d.last = 1'b1;
        end else begin
          wcur_d = bump(pos_q, size_q);
          wrem_d = item_q.msg_length;
          wact_d = 1'b1;
        end
        state_d = ST_EMIT;
      end
      ST_RD_HI: begin
        hi_d      = mem_rdata;
        mem_re    = 1'b1;
        mem_raddr = pos_q;
        pos_d     = bump(pos_q, size_q);
        state_d   = ST_RD_LO;
      end
      ST_RD_LO: begin
        // header complete, pos_q points at the first payload byte
        if ((pos_q == wp_q) && (hdr != '0)) begin
          res_d.status = lpmr_pkg::STATUS_EMPTY;
        end else if (hdr > AW'(size_q)) begin
          res_d.status = lpmr_pkg::STATUS_BAD_LEN;
          res_d.length = lpmr_pkg::LEN_W'(hdr);
        end else if (hdr > AW'(item_q.msg_length)) begin
          res_d.status = lpmr_pkg::STATUS_OVER_CAP;
          res_d.length = lpmr_pkg::LEN_W'(hdr);
        end else begin
          res_d.length = lpmr_pkg::LEN_W'(hdr);
          if (item_q.peek) begin
            res_d.next_position = nx[lpmr_pkg::POS_W-1:0];
          end
          if (hdr == '0) begin
            if (!item_q.peek) begin
              rp_d = pos_q;
            end
            res_d.last = 1'b1;
          end else begin
            rcur_d  = pos_q;
            rrem_d  = lpmr_pkg::LEN_W'(hdr);
            ract_d  = 1'b1;
            rpeek_d = item_q.peek;
          end
        end
        state_d = ST_EMIT;
      end
      ST_RD_BYTE: begin
        res_d.read_data = mem_rdata;
        rcur_d          = bump(rcur_q, size_q);
        rrem_d          = rrem_q - lpmr_pkg::LEN_W'(1);
        if (rrem_q == lpmr_pkg::LEN_W'(1)) begin
          if (!rpeek_q) begin
            rp_d = bump(rcur_q, size_q);
          end
          ract_d     = 1'b0;
          res_d.last = 1'b1;
        end
        state_d = ST_EMIT;
      end
      ST_EMIT: begin
        if (res_ready_i) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      size_q  <= SIZE_RST;
      wp_q    <= '0;
      rp_q    <= '0;
      wcur_q  <= '0;
      rcur_q  <= '0;
      wrem_q  <= '0;
      rrem_q  <= '0;
      wact_q  <= 1'b0;
      ract_q  <= 1'b0;
      rpeek_q <= 1'b0;
    end else begin
      state_q <= state_d;
      size_q  <= size_d;
      wp_q    <= wp_d;
      rp_q    <= rp_d;
      wcur_q  <= wcur_d;
      rcur_q  <= rcur_d;
      wrem_q  <= wrem_d;
      rrem_q  <= rrem_d;
      wact_q  <= wact_d;
      ract_q  <= ract_d;
      rpeek_q <= rpeek_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pos_q  <= pos_d;
    hi_q   <= hi_d;
    item_q <= item_d;
    res_q  <= res_d;
  end

  `LPMR_ASSERT(a_wp_in_ring, AW'(wp_q) < AW'(size_q), "write pointer beyond ring size")
  `LPMR_ASSERT(a_rp_in_ring, AW'(rp_q) < AW'(size_q), "read pointer beyond ring size")
  `LPMR_ASSERT_IMP(a_wr_rem, wact_q, wrem_q != '0, "open write with no bytes left")
  `LPMR_ASSERT_IMP(a_rd_rem, ract_q, rrem_q != '0, "open read with no bytes left")
  `LPMR_ASSERT_NXT(a_hdr_seq, state_q == ST_RD_HI, state_q == ST_RD_LO, "header read split")

endmodule

// ===== rtl/lpmr_out_stage.sv =====
// ----------------------------------------------------------------------------
// lpmr_out_stage
// output register between the sequencer and the result stream
// ----------------------------------------------------------------------------
module lpmr_out_stage (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  lpmr_pkg::res_t res_i,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  output lpmr_pkg::res_t res_o
);

  logic           valid_q, valid_d;
  lpmr_pkg::res_t data_q;

  assign in_ready_o = !valid_q || out_ready_i;

  always_comb begin
    valid_d = valid_q;
    if (in_valid_i && in_ready_o) begin
      valid_d = 1'b1;
    end else if (out_ready_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      data_q <= res_i;
    end
  end

  assign out_valid_o = valid_q;
  assign res_o       = data_q;

endmodule

// ===== rtl/length_prefixed_message_ring_core.sv =====
// path from accept to result on m_axis: write_byte, read_byte with no open read and any result
// decided at accept (no space, bad start, empty before the header) go from idle straight to emit,
// a write_open that fits passes the header write state, an open read_byte the byte read state
// and read_open the high and low header read states; one item at a time, the next is taken
// once the result enters the output register
// reset: pointers zero, no transfer open, ring size 1024, ring bytes undefined until written
// ----------------------------------------------------------------------------
// length_prefixed_message_ring_core
// byte ring of messages, each behind a two byte big-endian length header
// ----------------------------------------------------------------------------
module length_prefixed_message_ring_core #(
  parameter int unsigned RING_DEPTH = lpmr_pkg::RING_DEPTH_DEFAULT
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,

  // ring size register, a write empties the ring
  input  logic                             cfg_valid_i,
  output logic                             cfg_ready_o,
  input  logic [lpmr_pkg::CFG_W-1:0]       cfg_data_i,

  // request stream
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  // msg_length[15:0], data_byte[23:16], start_position[33:24], zero pad above
  input  logic [lpmr_pkg::TDATA_IN_W-1:0]  s_axis_tdata,
  // kind[1:0], peek[2]
  input  logic [lpmr_pkg::TUSER_IN_W-1:0]  s_axis_tuser,

  // result stream
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  // read_data[7:0], length[23:8], next_position[33:24], zero pad above
  output logic [lpmr_pkg::TDATA_OUT_W-1:0] m_axis_tdata,
  // status[2:0]
  output logic [lpmr_pkg::TUSER_OUT_W-1:0] m_axis_tuser,
  // last byte of a message read or write, or a zero length open
  output logic                             m_axis_tlast
);

  lpmr_pkg::item_t item;
  lpmr_pkg::res_t  eng_res;
  lpmr_pkg::res_t  out_res;
  logic            eng_valid;
  logic            eng_ready;

  // unpack the request transaction
  assign item.kind           = lpmr_pkg::kind_e'(s_axis_tuser[1:0]);
  assign item.peek           = s_axis_tuser[2];
  assign item.msg_length     = s_axis_tdata[15:0];
  assign item.data_byte      = s_axis_tdata[23:16];
  assign item.start_position = s_axis_tdata[33:24];

  // sequencer with the ring memory and all pointer state
  lpmr_engine #(
    .RING_DEPTH (RING_DEPTH)
  ) u_engine (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_data_i   (cfg_data_i),
    .item_valid_i (s_axis_tvalid),
    .item_ready_o (s_axis_tready),
    .item_i       (item),
    .res_valid_o  (eng_valid),
    .res_ready_i  (eng_ready),
    .res_o        (eng_res)
  );

  // output register so a waiting result does not hold the request side
  lpmr_out_stage u_out (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (eng_valid),
    .in_ready_o  (eng_ready),
    .res_i       (eng_res),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .res_o       (out_res)
  );

  // pack the result transaction
  assign m_axis_tdata = {{lpmr_pkg::TDATA_OUT_PAD{1'b0}}, out_res.next_position,
                         out_res.length, out_res.read_data};
  assign m_axis_tuser = out_res.status;
  assign m_axis_tlast = out_res.last;

endmodule

// ===== tb/tb_length_prefixed_message_ring_core.sv =====
// ----------------------------------------------------------------------------
// tb_length_prefixed_message_ring_core
// drives write/read requests into the message ring and compares every status
// and data reply against an in-bench model of the ring, over several sizes
// ----------------------------------------------------------------------------
module tb_length_prefixed_message_ring_core;
  import lpmr_pkg::*;

  logic                   clk_i = 1'b0;
  logic                   rst_ni = 1'b0;
  logic                   cfg_valid_i = 1'b0;
  logic                   cfg_ready_o;
  logic [CFG_W-1:0]       cfg_data_i = '0;
  logic                   s_axis_tvalid = 1'b0;
  logic                   s_axis_tready;
  // msg_length[15:0], data_byte[23:16], start_position[33:24], zero pad above
  logic [TDATA_IN_W-1:0]  s_axis_tdata = '0;
  // kind[1:0], peek[2]
  logic [TUSER_IN_W-1:0]  s_axis_tuser = '0;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready = 1'b0;
  // read_data[7:0], length[23:8], next_position[33:24], zero pad above
  logic [TDATA_OUT_W-1:0] m_axis_tdata;
  // status[2:0]
  logic [TUSER_OUT_W-1:0] m_axis_tuser;
  logic                   m_axis_tlast;

  length_prefixed_message_ring_core u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  always #5 clk_i = ~clk_i;

  // ring model state
  logic [7:0]  ring_mem     [1024];
  bit          ring_written [1024];
  logic [10:0] size_reg = 11'(RING_SIZE_RESET);
  int unsigned wr_ptr, rd_ptr, wr_cur, wr_left, rd_cur, rd_left;
  bit          wr_open, rd_open, rd_peek;

  res_t        replies_due [$];
  int unsigned items_sent, replies_seen, mismatches, cfg_writes;
  int unsigned status_count [8];
  int unsigned walk_pos;
  int unsigned stall_left = 0;
  bit          calm = 1'b0;

  function automatic int unsigned usable_size();
    int unsigned s;
    s = size_reg;
    if (s < MIN_SIZE) s = MIN_SIZE;
    if (s > RING_DEPTH_DEFAULT) s = RING_DEPTH_DEFAULT;
    return s;
  endfunction

  function automatic int unsigned step_pos(input int unsigned p, input int unsigned sz);
    return (p + 1 >= sz) ? 0 : p + 1;
  endfunction

  function automatic void ring_put(input int unsigned p, input logic [7:0] v);
    ring_mem[p]     = v;
    ring_written[p] = 1'b1;
  endfunction

  // a read of a never written ring byte is kept out of the stimulus
  function automatic bit touches_blank(input item_t it);
    int unsigned sz, r;
    sz = usable_size();
    if (it.kind == KIND_RD_BYTE) return rd_open && !ring_written[rd_cur];
    if (it.kind != KIND_RD_OPEN) return 1'b0;
    r = it.peek ? int'(it.start_position) : rd_ptr;
    if ((it.peek && it.start_position >= sz) || r == wr_ptr) return 1'b0;
    if (!ring_written[r]) return 1'b1;
    r = step_pos(r, sz);
    return (r != wr_ptr) && !ring_written[r];
  endfunction

  // advances the ring model by one request and returns its reply
  function automatic res_t ring_reply(input item_t it);
    res_t        rep;
    int unsigned sz, w, r, need, h, nx;
    bit          full;
    sz = usable_size();
    rep = '0;
    rep.status = STATUS_OK;
    case (it.kind)
      KIND_WR_OPEN: begin
        w = wr_ptr;
        r = rd_ptr;
        need = it.msg_length + HDR_BYTES;
        wr_open = 1'b0;
        full = (w < r) ? (w + need >= r) : ((sz - w) + r < need);
        if (full) begin
          rep.status = STATUS_NO_SPACE;
        end else begin
          ring_put(w, it.msg_length[15:8]);
          w = step_pos(w, sz);
          ring_put(w, it.msg_length[7:0]);
          w = step_pos(w, sz);
          if (it.msg_length == 0) begin
            wr_ptr = w;
            rep.last = 1'b1;
          end else begin
            wr_cur = w;
            wr_left = it.msg_length;
            wr_open = 1'b1;
          end
        end
      end
      KIND_WR_BYTE: begin
        if (!wr_open) begin
          rep.status = STATUS_NONE_OPEN;
        end else begin
          ring_put(wr_cur, it.data_byte);
          wr_cur = step_pos(wr_cur, sz);
          wr_left = (wr_left - 1) & 16'hffff;
          if (wr_left == 0) begin
            wr_ptr = wr_cur;
            wr_open = 1'b0;
            rep.last = 1'b1;
          end
        end
      end
      KIND_RD_OPEN: begin
        w = wr_ptr;
        r = it.peek ? int'(it.start_position) : rd_ptr;
        rd_open = 1'b0;
        if (it.peek && it.start_position >= sz) begin
          rep.status = STATUS_BAD_START;
        end else if (r == w) begin
          rep.status = STATUS_EMPTY;
        end else begin
          h = {16'd0, ring_mem[r], 8'd0};
          r = step_pos(r, sz);
          if (r == w) begin
            rep.status = STATUS_EMPTY;
          end else begin
            h = h | ring_mem[r];
            r = step_pos(r, sz);
            // header runs into the write pointer while a body is still due
            if (r == w && h != 0) begin
              rep.status = STATUS_EMPTY;
            end else if (h > sz) begin
              rep.status = STATUS_BAD_LEN;
              rep.length = h[15:0];
            end else if (h > it.msg_length) begin
              rep.status = STATUS_OVER_CAP;
              rep.length = h[15:0];
            end else begin
              nx = r + h;
              if (nx >= sz) nx = nx - sz;
              rep.length = h[15:0];
              if (it.peek) rep.next_position = nx[9:0];
              // an empty message is passed at once
              if (h == 0) begin
                if (!it.peek) rd_ptr = r;
                rep.last = 1'b1;
              end else begin
                rd_cur = r;
                rd_left = h;
                rd_open = 1'b1;
                rd_peek = it.peek;
              end
            end
          end
        end
      end
      default: begin
        if (!rd_open) begin
          rep.status = STATUS_NONE_OPEN;
        end else begin
          rep.read_data = ring_mem[rd_cur];
          rd_cur = step_pos(rd_cur, sz);
          rd_left = (rd_left - 1) & 16'hffff;
          if (rd_left == 0) begin
            if (!rd_peek) rd_ptr = rd_cur;
            rd_open = 1'b0;
            rep.last = 1'b1;
          end
        end
      end
    endcase
    return rep;
  endfunction

  task automatic report_mismatch(input string what, input int unsigned got,
                                 input int unsigned want);
    mismatches++;
    if (mismatches <= 30)
      $display("mismatch in %s at reply %0d: got 0x%0h, expected 0x%0h",
               what, replies_seen, got, want);
  endtask

  // one request transaction, the model is advanced at the accepting edge
  task automatic send_request(input kind_e kind, input int unsigned len,
                              input logic [7:0] data, input bit peek,
                              input int unsigned start, output res_t rep);
    item_t it;
    it.kind           = kind;
    it.msg_length     = len[15:0];
    it.data_byte      = data;
    it.peek           = peek;
    it.start_position = start[9:0];
    if (touches_blank(it)) begin
      it.kind = KIND_RD_OPEN;
      it.peek = 1'b0;
    end
    if (touches_blank(it)) it.kind = KIND_WR_BYTE;
    if (!calm && $urandom_range(0, 3) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 7)) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {6'd0, it.start_position, it.data_byte, it.msg_length};
    s_axis_tuser  <= {it.peek, it.kind};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    rep = ring_reply(it);
    replies_due.push_back(rep);
    items_sent++;
  endtask

  // stop sending and let every outstanding reply come back
  task automatic settle_ring();
    s_axis_tvalid <= 1'b0;
    while (replies_due.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_ring_size(input int unsigned value);
    settle_ring();
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= value[CFG_W-1:0];
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    cfg_valid_i <= 1'b0;
    size_reg = value[CFG_W-1:0];
    wr_ptr  = 0;
    rd_ptr  = 0;
    wr_open = 1'b0;
    rd_open = 1'b0;
    wr_left = 0;
    rd_left = 0;
    cfg_writes++;
  endtask

  function automatic int unsigned pick_length(input int unsigned sz);
    int unsigned roll;
    roll = $urandom_range(0, 19);
    if (roll == 0) return 0;
    if (roll == 1) return $urandom_range(0, 16'hffff);
    // exact fit and one past it, only where the ring is small
    if (roll == 2 && sz <= 128) return sz - HDR_BYTES + $urandom_range(0, 1);
    return $urandom_range(1, (sz / 3 < 24) ? sz / 3 : 24);
  endfunction

  task automatic test_opcodes_after_reset();
    res_t rep;
    send_request(KIND_RD_BYTE, 0, 8'h00, 1'b0, 0, rep);
    send_request(KIND_WR_BYTE, 0, 8'hff, 1'b0, 0, rep);
    send_request(KIND_RD_OPEN, 16'hffff, 8'h00, 1'b0, 0, rep);
    send_request(KIND_WR_OPEN, 16'hffff, 8'h00, 1'b0, 0, rep);
    // zero length write commits at once, zero length read consumes it
    send_request(KIND_WR_OPEN, 0, 8'h00, 1'b0, 0, rep);
    send_request(KIND_RD_OPEN, 0, 8'h00, 1'b0, 0, rep);
    send_request(KIND_WR_OPEN, 4, 8'h00, 1'b0, 0, rep);
    send_request(KIND_WR_BYTE, 0, 8'hff, 1'b0, 0, rep);
    send_request(KIND_WR_BYTE, 0, 8'hff, 1'b0, 0, rep);
    send_request(KIND_WR_BYTE, 0, 8'h00, 1'b0, 0, rep);
    send_request(KIND_WR_BYTE, 0, 8'h01, 1'b0, 0, rep);
    send_request(KIND_RD_OPEN, 3, 8'h00, 1'b0, 0, rep);
    // body bytes read as a header: length beyond the ring
    send_request(KIND_RD_OPEN, 16'hffff, 8'h00, 1'b1, 4, rep);
    // header cut off by the write pointer
    send_request(KIND_RD_OPEN, 16'hffff, 8'h00, 1'b1, 7, rep);
    send_request(KIND_RD_OPEN, 16'hffff, 8'h00, 1'b1, 2, rep);
    send_request(KIND_RD_BYTE, 0, 8'h00, 1'b0, 0, rep);
    // reopen drops the peek read
    send_request(KIND_RD_OPEN, 4, 8'h00, 1'b0, 0, rep);
    repeat (4) send_request(KIND_RD_BYTE, 0, 8'h00, 1'b0, 0, rep);
    // reopen drops the open write
    send_request(KIND_WR_OPEN, 1, 8'h00, 1'b0, 0, rep);
    send_request(KIND_WR_OPEN, 2, 8'h00, 1'b0, 0, rep);
    send_request(KIND_WR_BYTE, 0, 8'haa, 1'b0, 0, rep);
    send_request(KIND_WR_BYTE, 0, 8'h55, 1'b0, 0, rep);
  endtask

  task automatic test_ring_size_extremes();
    res_t rep;
    // below the minimum, clamped to 8
    write_ring_size(0);
    send_request(KIND_RD_OPEN, 16'hffff, 8'h00, 1'b1, 8, rep);
    send_request(KIND_RD_OPEN, 16'hffff, 8'h00, 1'b1, 1023, rep);
    send_request(KIND_WR_OPEN, 4, 8'h00, 1'b0, 0, rep);
    repeat (4) send_request(KIND_WR_BYTE, 0, 8'h5a, 1'b0, 0, rep);
    send_request(KIND_WR_OPEN, 5, 8'h00, 1'b0, 0, rep);
    send_request(KIND_RD_OPEN, 16'hffff, 8'h00, 1'b1, 0, rep);
    send_request(KIND_RD_OPEN, 16'hffff, 8'h00, 1'b0, 0, rep);
    repeat (4) send_request(KIND_RD_BYTE, 0, 8'h00, 1'b0, 0, rep);
    // above the maximum, clamped to the ring depth: exact fit then one over
    write_ring_size(2047);
    send_request(KIND_WR_OPEN, 1020, 8'h00, 1'b0, 0, rep);
    send_request(KIND_WR_OPEN, 1021, 8'h00, 1'b0, 0, rep);
  endtask

  task automatic run_traffic(input int unsigned budget);
    int unsigned first, sz, len, cap, pick;
    res_t        rep;
    first = items_sent;
    walk_pos = rd_ptr;
    while (items_sent - first < budget) begin
      sz = usable_size();
      pick = $urandom_range(0, 99);
      if (pick < 35) begin
        // whole message write, now and then cut short
        len = pick_length(sz);
        send_request(KIND_WR_OPEN, len, 8'h00, 1'b0, 0, rep);
        if (rep.status == STATUS_OK) begin
          for (int unsigned i = 0; i < len; i++) begin
            if ($urandom_range(0, 59) == 0) break;
            send_request(KIND_WR_BYTE, 0, 8'($urandom_range(0, 255)), 1'b0, 0, rep);
          end
        end
      end else if (pick < 65) begin
        // consume the oldest message
        pick = $urandom_range(0, 9);
        cap = 16'hffff;
        if (pick == 0) cap = $urandom_range(0, 16'hffff);
        if (pick == 1) cap = $urandom_range(0, 8);
        if (pick == 2 && ring_written[rd_ptr] && ring_written[step_pos(rd_ptr, sz)])
          cap = {ring_mem[rd_ptr], ring_mem[step_pos(rd_ptr, sz)]} - $urandom_range(0, 1);
        send_request(KIND_RD_OPEN, cap, 8'h00, 1'b0, 0, rep);
        if (rep.status == STATUS_OK) begin
          for (int unsigned i = 0; i < rep.length && !rep.last; i++) begin
            if ($urandom_range(0, 59) == 0) break;
            send_request(KIND_RD_BYTE, 0, 8'h00, 1'b0, 0, rep);
          end
        end
      end else if (pick < 80) begin
        // walk the stored messages without consuming them
        if (walk_pos >= sz) walk_pos = rd_ptr;
        send_request(KIND_RD_OPEN, 16'hffff, 8'h00, 1'b1, walk_pos, rep);
        if (rep.status == STATUS_OK) begin
          walk_pos = rep.next_position;
          for (int unsigned i = 0; i < rep.length && !rep.last; i++) begin
            if ($urandom_range(0, 29) == 0) break;
            send_request(KIND_RD_BYTE, 0, 8'h00, 1'b0, 0, rep);
          end
        end else begin
          walk_pos = rd_ptr;
        end
      end else begin
        // noise
        send_request(kind_e'($urandom_range(0, 3)), $urandom_range(0, 16'hffff),
                     8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
                     $urandom_range(0, 1023), rep);
      end
    end
  endtask

  task automatic test_random_traffic();
    int unsigned phase_sizes [8] = '{8, 1024, 13, 2047, 100, 0, 517, 1024};
    for (int ph = 0; ph < 8; ph++) begin
      // the last phase runs with no idling on either side
      calm = (ph == 7);
      write_ring_size(phase_sizes[ph]);
      run_traffic(230);
    end
  endtask

  // result side: random stall bursts
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
    end else if (stall_left != 0) begin
      m_axis_tready <= 1'b0;
      stall_left    <= stall_left - 1;
    end else if (!calm && $urandom_range(0, 5) == 0) begin
      m_axis_tready <= 1'b0;
      stall_left    <= $urandom_range(0, 6);
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  // every result transaction against the oldest outstanding reply
  always @(posedge clk_i) begin
    res_t due;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      replies_seen++;
      if (replies_due.size() == 0) begin
        report_mismatch("reply with nothing outstanding", m_axis_tuser, 0);
      end else begin
        due = replies_due.pop_front();
        status_count[due.status]++;
        if (m_axis_tuser !== due.status)
          report_mismatch("status", m_axis_tuser, due.status);
        if (m_axis_tdata[7:0] !== due.read_data)
          report_mismatch("read_data", m_axis_tdata[7:0], due.read_data);
        if (m_axis_tdata[23:8] !== due.length)
          report_mismatch("length", m_axis_tdata[23:8], due.length);
        if (m_axis_tdata[33:24] !== due.next_position)
          report_mismatch("next_position", m_axis_tdata[33:24], due.next_position);
        if (m_axis_tlast !== due.last)
          report_mismatch("last", m_axis_tlast, due.last);
      end
    end
  end

  initial begin
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_opcodes_after_reset();
    test_ring_size_extremes();
    test_random_traffic();
    settle_ring();
    repeat (8) @(posedge clk_i);
    if (replies_due.size() != 0)
      report_mismatch("replies never returned", replies_due.size(), 0);
    $display("covered %0d requests, %0d replies, %0d ring size writes", items_sent,
             replies_seen, cfg_writes);
    $display("ok %0d, no space %0d, empty %0d, over cap %0d, bad len %0d, none %0d, start %0d",
             status_count[STATUS_OK], status_count[STATUS_NO_SPACE],
             status_count[STATUS_EMPTY], status_count[STATUS_OVER_CAP],
             status_count[STATUS_BAD_LEN], status_count[STATUS_NONE_OPEN],
             status_count[STATUS_BAD_START]);
    if (mismatches == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  initial begin
    #4000000;
    $display("FAILED: results differ");
    $finish;
  end

endmodule
